// File: rtl/sandpile_grain_relaxation_defines.svh
// Assertion macros used by the checker file of the grain relaxation block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef SANDPILE_GRAIN_RELAXATION_DEFINES_SVH
`define SANDPILE_GRAIN_RELAXATION_DEFINES_SVH

// clocked check, off while reset is asserted
`define SGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define SGR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: rtl/sgr_pkg.sv
// Shared types and constants of the grain relaxation block.
// No dependencies.
package sgr_pkg;

  localparam int unsigned HeightW = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ThrW    = 4;
  localparam int unsigned CoordW  = 6;
  localparam int unsigned AmountW = 8;

  localparam logic [ThrW-1:0] ThrMin   = 4'd4;
  localparam logic [ThrW-1:0] ThrReset = 4'd4;

  typedef enum logic [0:0] {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [ThrW-1:0] thr;
    logic            rd_en;
    logic            clr;
    logic            add_we;
    logic            load;
    logic            step;
    logic            last_row;
    logic            sweep_start;
    logic            cnt_clear;
    logic            shift;
  } ctrl_t;

endpackage

// File: rtl/sgr_if.sv
// Request and response channel interfaces of the grain relaxation block.
// Depends on sgr_pkg.
interface sgr_req_if;
  import sgr_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [CoordW-1:0]  row;
  logic [CoordW-1:0]  col;
  logic [AmountW-1:0] amount;

  modport source (output valid, action, row, col, amount, input ready);
  modport sink (input valid, action, row, col, amount, output ready);
endinterface

interface sgr_rsp_if;
  import sgr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CountW-1:0]  topple_count;
  logic [HeightW-1:0] cell_height;

  modport source (output valid, topple_count, cell_height, input ready);
  modport sink (input valid, topple_count, cell_height, output ready);
endinterface

// File: rtl/sandpile_grain_relaxation.sv
// Top level of the grain relaxation block: sequencer, threshold register, cell row.
// Depends on sgr_pkg, sgr_if and sgr_cell.
//
// Usage
//   req_i  : requests {action, row, col, amount}; taken when valid and ready are high.
//            An add drops amount grains on (row, col) and relaxes the grid; a read
//            returns one height. One request is worked on at a time.
//   rsp_o  : one response per request {topple_count, cell_height}, held in an output
//            register; a stalled receiver holds it while the next request is taken.
//   cfg_we_i / cfg_wdata_i : topple threshold, write only while idle; below 4 acts as 4.
// Operation
//   read : the height of (row, col) is read from memory and registered as the response.
//   add  : the target height is read and written back with the grains added; the grid is
//          then swept until a sweep topples no cell. Each sweep moves one grid row per
//          cycle through the row of SIDE column cells, one memory read and one write per
//          cell per cycle; topple counts then shift out of the cell chain into a sum.
// Reset
//   All heights are cleared by a pass over every row after reset, during which no
//   request is taken; the threshold returns to 4.
module sandpile_grain_relaxation #(
  parameter int unsigned SIDE = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sgr_pkg::ThrW-1:0]   cfg_wdata_i,
  sgr_req_if.sink                    req_i,
  sgr_rsp_if.source                  rsp_o
);
  import sgr_pkg::*;

  localparam int unsigned AW = $clog2(SIDE);
  localparam int unsigned PW = $clog2(SIDE + 2);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_TGT_RD = 8'b0000_0100,
    ST_TGT_WR = 8'b0000_1000,
    ST_SWEEP  = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_HT_RD  = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_e;

  state_e             st_q, st_d;
  logic [PW-1:0]      ph_q, ph_d;
  logic               first_q, first_d;
  logic [CountW-1:0]  sum_q, sum_d;
  logic [ThrW-1:0]    thr_q, thr_eff;
  logic               rsp_valid_q, rsp_valid_d;
  logic               res_load;
  logic [CountW-1:0]  cnt_res_q;
  logic [HeightW-1:0] ht_res_q;

  logic               action_q;
  logic [CoordW-1:0]  row_q, col_q;
  logic [AmountW-1:0] amount_q;

  ctrl_t              ctl;
  logic [AW-1:0]      raddr, waddr;
  logic               tgt_in;
  logic [AW-1:0]      row_a, col_a;
  logic               any_all;
  logic [CountW:0]    sum_wide;

  logic [SIDE-1:0]    flag_w, any_w;
  logic [CountW-1:0]  cnt_w   [SIDE];
  logic [HeightW-1:0] rdata_w [SIDE];

  assign tgt_in   = (32'(row_q) < SIDE) && (32'(col_q) < SIDE);
  assign row_a    = AW'(row_q);
  assign col_a    = AW'(col_q);
  assign thr_eff  = (thr_q < ThrMin) ? ThrMin : thr_q;
  assign any_all  = |any_w;
  assign sum_wide = {1'b0, sum_q} + {1'b0, cnt_w[0]};

  always_comb begin
    st_d        = st_q;
    ph_d        = ph_q;
    first_d     = first_q;
    sum_d       = sum_q;
    ctl         = '0;
    ctl.thr     = thr_eff;
    raddr       = row_a;
    waddr       = row_a;
    res_load    = 1'b0;
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (st_q)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        waddr   = AW'(ph_q);
        if (ph_q == PW'(SIDE - 1)) begin
          st_d = ST_IDLE;
          ph_d = '0;
        end else begin
          ph_d = ph_q + PW'(1);
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          st_d  = (req_i.action == ACT_READ) ? ST_HT_RD : ST_TGT_RD;
          sum_d = '0;
        end
      end
      ST_TGT_RD: begin
        ctl.rd_en = 1'b1;
        st_d      = ST_TGT_WR;
      end
      ST_TGT_WR: begin
        ctl.add_we    = 1'b1;
        ctl.cnt_clear = 1'b1;
        ph_d          = '0;
        first_d       = 1'b1;
        st_d          = ST_SWEEP;
      end
      ST_SWEEP: begin
        raddr        = AW'(ph_q);
        waddr        = AW'(ph_q - PW'(2));
        ctl.rd_en    = ph_q < PW'(SIDE);
        ctl.load     = ph_q == PW'(1);
        ctl.step     = ph_q >= PW'(2);
        ctl.last_row = ph_q == PW'(SIDE + 1);
        if (ph_q == '0) begin
          if (!first_q && !any_all) begin
            st_d = ST_SUM;
          end else begin
            ctl.sweep_start = 1'b1;
            first_d         = 1'b0;
            ph_d            = PW'(1);
          end
        end else if (ph_q == PW'(SIDE + 1)) begin
          ph_d = '0;
        end else begin
          ph_d = ph_q + PW'(1);
        end
      end
      ST_SUM: begin
        ctl.shift = 1'b1;
        sum_d     = sum_wide[CountW] ? '1 : sum_wide[CountW-1:0];
        if (ph_q == PW'(SIDE - 1)) begin
          ph_d = '0;
          st_d = ST_HT_RD;
        end else begin
          ph_d = ph_q + PW'(1);
        end
      end
      ST_HT_RD: begin
        ctl.rd_en = 1'b1;
        st_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          res_load    = 1'b1;
          rsp_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_CLEAR;
        ph_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      ph_q        <= '0;
      first_q     <= 1'b0;
      sum_q       <= '0;
      thr_q       <= ThrReset;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ph_q        <= ph_d;
      first_q     <= first_d;
      sum_q       <= sum_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      action_q <= req_i.action;
      row_q    <= req_i.row;
      col_q    <= req_i.col;
      amount_q <= req_i.amount;
    end
    if (res_load) begin
      cnt_res_q <= (action_q == ACT_READ) ? '0 : sum_q;
      ht_res_q  <= tgt_in ? rdata_w[col_a] : '0;
    end
  end

  for (genvar j = 0; j < SIDE; j++) begin : g_cell
    logic              fl, fr, sel;
    logic [CountW-1:0] cin;
    if (j == 0) begin : g_l
      assign fl = 1'b0;
    end else begin : g_l
      assign fl = flag_w[j-1];
    end
    if (j == SIDE - 1) begin : g_r
      assign fr  = 1'b0;
      assign cin = '0;
    end else begin : g_r
      assign fr  = flag_w[j+1];
      assign cin = cnt_w[j+1];
    end
    assign sel = tgt_in && (32'(col_q) == j);

    sgr_cell #(
      .SIDE(SIDE)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .raddr_i  (raddr),
      .waddr_i  (waddr),
      .sel_i    (sel),
      .amount_i (amount_q),
      .flag_l_i (fl),
      .flag_r_i (fr),
      .cnt_i    (cin),
      .flag_o   (flag_w[j]),
      .any_o    (any_w[j]),
      .cnt_o    (cnt_w[j]),
      .rdata_o  (rdata_w[j])
    );
  end

  assign req_i.ready        = (st_q == ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.topple_count = cnt_res_q;
  assign rsp_o.cell_height  = ht_res_q;

endmodule

// File: rtl/sgr_cell.sv
// One grid column: its height memory, a three-row window and a topple counter.
// Depends on sgr_pkg; instantiated in a row by sandpile_grain_relaxation.
module sgr_cell #(
  parameter int unsigned SIDE = 64,
  localparam int unsigned AW = $clog2(SIDE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sgr_pkg::ctrl_t                ctl_i,
  input  logic [AW-1:0]                 raddr_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic                          sel_i,
  input  logic [sgr_pkg::AmountW-1:0]   amount_i,
  input  logic                          flag_l_i,
  input  logic                          flag_r_i,
  input  logic [sgr_pkg::CountW-1:0]    cnt_i,
  output logic                          flag_o,
  output logic                          any_o,
  output logic [sgr_pkg::CountW-1:0]    cnt_o,
  output logic [sgr_pkg::HeightW-1:0]   rdata_o
);
  import sgr_pkg::*;

  logic [HeightW-1:0] mem_q [SIDE];
  logic [HeightW-1:0] rdata_q;
  logic [HeightW-1:0] prev_q, cur_q;
  logic [CountW-1:0]  cnt_q;
  logic               any_q;

  logic [HeightW-1:0] thr;
  logic               fc, fp, fn;
  logic [2:0]         inc;
  logic [HeightW-1:0] upd;
  logic               we;
  logic [HeightW-1:0] wdata;

  assign thr = HeightW'(ctl_i.thr);
  assign fc  = cur_q >= thr;
  assign fp  = prev_q >= thr;
  assign fn  = !ctl_i.last_row && (rdata_q >= thr);
  assign inc = {2'b00, fp} + {2'b00, fn} + {2'b00, flag_l_i} + {2'b00, flag_r_i};
  assign upd = cur_q - (fc ? thr : '0) + HeightW'(inc);

  always_comb begin
    we    = 1'b0;
    wdata = upd;
    if (ctl_i.clr) begin
      we    = 1'b1;
      wdata = '0;
    end else if (ctl_i.add_we && sel_i) begin
      we    = 1'b1;
      wdata = rdata_q + HeightW'(amount_i);
    end else if (ctl_i.step) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr_i] <= wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // old values of the row being updated and of the row before it
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      prev_q <= '0;
      cur_q  <= rdata_q;
    end else if (ctl_i.step) begin
      prev_q <= cur_q;
      cur_q  <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      any_q <= 1'b0;
    end else begin
      if (ctl_i.cnt_clear) begin
        cnt_q <= '0;
      end else if (ctl_i.shift) begin
        cnt_q <= cnt_i;
      end else if (ctl_i.step && fc && (cnt_q != '1)) begin
        cnt_q <= cnt_q + CountW'(1);
      end
      if (ctl_i.sweep_start) begin
        any_q <= 1'b0;
      end else if (ctl_i.step && fc) begin
        any_q <= 1'b1;
      end
    end
  end

  assign flag_o  = fc;
  assign any_o   = any_q;
  assign cnt_o   = cnt_q;
  assign rdata_o = rdata_q;

endmodule

// File: rtl/sgr_checker.sv
// Port-level checks of the grain relaxation block, bound to its top level.
// Depends on sgr_pkg and sandpile_grain_relaxation_defines.svh.
`include "sandpile_grain_relaxation_defines.svh"

module sgr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [sgr_pkg::CountW-1:0]   rsp_count_i,
  input logic [sgr_pkg::HeightW-1:0]  rsp_height_i
);
  import sgr_pkg::*;

  `SGR_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped")
  `SGR_ASSERT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_count_i) && $stable(rsp_height_i), "stalled response changed")
  `SGR_ASSERT(a_one_req, req_valid_i && req_ready_i |=> !req_ready_i, "second request taken while busy")
  `SGR_ASSERT(a_settled, rsp_valid_i |-> (rsp_height_i[HeightW-1:ThrW] == '0), "reported height above any threshold")
  `SGR_ASSERT_RST(a_rst_quiet, !rst_ni |=> !rsp_valid_i && !req_ready_i, "activity during reset")

endmodule

bind sandpile_grain_relaxation sgr_checker u_sgr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_count_i  (rsp_o.topple_count),
  .rsp_height_i (rsp_o.cell_height)
);
